FILE: hdl/ssr_pkg.sv
// Shared constants for the streaming substring replace block.
`default_nettype none

package ssr_pkg;

    localparam int BYTE_W    = 8;
    localparam int LEN_W     = 4;
    localparam int CFG_IDX_W = 4;
    localparam int CFG_W     = 64;

    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

    localparam cfg_idx_t CFG_PATTERN_LEN   = cfg_idx_t'(0);
    localparam cfg_idx_t CFG_PATTERN_BYTES = cfg_idx_t'(1);
    localparam cfg_idx_t CFG_REPLACE_LEN   = cfg_idx_t'(2);
    localparam cfg_idx_t CFG_REPLACE_BYTES = cfg_idx_t'(3);

endpackage

`default_nettype wire

FILE: hdl/streaming_substring_replace.sv
// Streaming substring replace: top level.
//
// Bytes enter on the s_* stream, one per beat, with s_tlast on the final byte
// of a string. Every leftmost, non-overlapping occurrence of the configured
// pattern is replaced by the configured replacement; rewritten bytes leave on
// the m_* stream, m_tlast on the final byte of the rewritten string.
// Bytes that may still start a match are held inside and flushed at s_tlast.
// The cfg_* channel writes one register per beat (always ready): index 0
// pattern_len, 1 pattern_bytes, 2 replace_len, 3 replace_bytes; other indexes
// are ignored. Write it only while the block is idle.
// Each accepted byte is evaluated in the cycle it is accepted; its results
// (0 to max(PAT_MAX, REP_MAX) bytes) start on m_* the following cycle and
// leave at one byte per cycle while m_tready is high, from an output burst
// register. The next byte is taken in the cycle its predecessor's last
// result is taken, so a plain stream runs at one byte per cycle while
// m_tready is high. When m_tready is low the burst holds and s_tready stays
// low until its final byte can leave.
// Reset empties the held bytes and clears all but the payload registers:
// both lengths zero, so bytes pass through unchanged until configured.
`default_nettype none

module streaming_substring_replace #(
    parameter int PAT_MAX = 8,
    parameter int REP_MAX = 8
) (
    input  wire                               clk,
    input  wire                               rst_n,
    input  wire                               s_tvalid,
    output logic                              s_tready,
    input  wire  [ssr_pkg::BYTE_W-1:0]        s_tdata,   // [7:0] char_in
    input  wire                               s_tlast,   // last_in
    output logic                              m_tvalid,
    input  wire                               m_tready,
    output logic [ssr_pkg::BYTE_W-1:0]        m_tdata,   // [7:0] char_out
    output logic                              m_tlast,   // last_out
    input  wire                               cfg_valid,
    output logic                              cfg_ready,
    input  wire  [ssr_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire  [ssr_pkg::CFG_W-1:0]         cfg_data
);

    localparam int BW      = ssr_pkg::BYTE_W;
    localparam int LW      = ssr_pkg::LEN_W;
    localparam int OUT_MAX = (PAT_MAX > REP_MAX) ? PAT_MAX : REP_MAX;

    // configuration
    logic [LW-1:0]              pattern_len_reg;
    logic [ssr_pkg::CFG_W-1:0]  pattern_bytes_reg;
    logic [LW-1:0]              replace_len_reg;
    logic [ssr_pkg::CFG_W-1:0]  replace_bytes_reg;

    // match state
    logic [BW-1:0]  held_reg  [PAT_MAX];
    logic [BW-1:0]  held_next [PAT_MAX];
    logic [LW-1:0]  held_cnt_reg;
    logic [LW-1:0]  held_cnt_next;

    // output burst
    logic [BW-1:0]  burst_reg  [OUT_MAX];
    logic [BW-1:0]  burst_next [OUT_MAX];
    logic [LW-1:0]  rem_reg;
    logic [LW-1:0]  rem_next;
    logic           blast_reg;
    logic           blast_next;

    // evaluation
    logic [BW-1:0]  buf_b [PAT_MAX];
    logic [BW-1:0]  emit  [OUT_MAX];
    logic [LW-1:0]  emit_cnt;
    logic [LW-1:0]  k_cl;
    logic [LW-1:0]  n_len;
    logic [LW-1:0]  plen;
    logic [LW-1:0]  rlen;
    logic           enabled;
    logic           full_hit;
    logic [PAT_MAX:0] match_at;
    logic [LW-1:0]  sel;
    logic           in_acc;
    logic           out_take;

    assign cfg_ready = 1'b1;
    assign m_tvalid  = (rem_reg != '0);
    assign m_tdata   = burst_reg[0];
    assign m_tlast   = blast_reg && (rem_reg == LW'(1));
    assign s_tready  = (rem_reg == '0) || ((rem_reg == LW'(1)) && m_tready);
    assign in_acc    = s_tvalid && s_tready;
    assign out_take  = m_tvalid && m_tready;

    always_comb
    begin
        k_cl  = (held_cnt_reg >= LW'(PAT_MAX)) ? LW'(PAT_MAX - 1) : held_cnt_reg;
        n_len = k_cl + LW'(1);
        plen  = (pattern_len_reg > LW'(PAT_MAX)) ? LW'(PAT_MAX) : pattern_len_reg;
        rlen  = (replace_len_reg > LW'(REP_MAX)) ? LW'(REP_MAX) : replace_len_reg;
        enabled = (plen != '0) && (rlen != '0);

        // held bytes with the new byte appended
        for (int i = 0; i < PAT_MAX; i++)
        begin
            if (LW'(i) < k_cl)
                buf_b[i] = held_reg[i];
            else if (LW'(i) == k_cl)
                buf_b[i] = s_tdata;
            else
                buf_b[i] = '0;
        end

        // match_at[s]: bytes s..n-1 form a prefix of the pattern
        for (int s = 0; s <= PAT_MAX; s++)
        begin
            match_at[s] = 1'b1;
            if (LW'(s) > n_len)
                match_at[s] = 1'b0;
            else if ((n_len - LW'(s)) > plen)
                match_at[s] = 1'b0;
            for (int j = 0; j < PAT_MAX; j++)
            begin
                if ((s + j < PAT_MAX) && (LW'(s + j) < n_len) &&
                    (buf_b[(s + j) % PAT_MAX] != pattern_bytes_reg[BW*j +: BW]))
                    match_at[s] = 1'b0;
            end
        end

        // smallest shift that leaves a pattern prefix; s == n always qualifies
        sel = LW'(PAT_MAX);
        for (int s = PAT_MAX; s >= 0; s--)
        begin
            if (match_at[s])
                sel = LW'(s);
        end

        full_hit = (n_len == plen) && match_at[0];

        for (int i = 0; i < OUT_MAX; i++)
            emit[i] = '0;
        for (int j = 0; j < PAT_MAX; j++)
            held_next[j] = held_reg[j];
        emit_cnt      = '0;
        held_cnt_next = '0;

        if (!enabled)
        begin
            for (int i = 0; i < PAT_MAX; i++)
                emit[i] = buf_b[i];
            emit_cnt = n_len;
        end
        else if (full_hit)
        begin
            for (int i = 0; i < REP_MAX; i++)
                emit[i] = replace_bytes_reg[BW*i +: BW];
            emit_cnt = rlen;
        end
        else
        begin
            for (int i = 0; i < PAT_MAX; i++)
                emit[i] = buf_b[i];
            if (s_tlast)
            begin
                emit_cnt = n_len;
            end
            else
            begin
                emit_cnt      = sel;
                held_cnt_next = n_len - sel;
                for (int s = 0; s <= PAT_MAX; s++)
                begin
                    if (sel == LW'(s))
                    begin
                        for (int j = 0; j < PAT_MAX; j++)
                        begin
                            if (j + s < PAT_MAX)
                                held_next[j] = buf_b[(j + s) % PAT_MAX];
                        end
                    end
                end
            end
        end
    end

    always_comb
    begin
        for (int i = 0; i < OUT_MAX; i++)
            burst_next[i] = burst_reg[i];
        rem_next   = rem_reg;
        blast_next = blast_reg;
        if (in_acc)
        begin
            for (int i = 0; i < OUT_MAX; i++)
                burst_next[i] = emit[i];
            rem_next   = emit_cnt;
            blast_next = s_tlast;
        end
        else if (out_take)
        begin
            for (int i = 0; i < OUT_MAX; i++)
                burst_next[i] = (i + 1 < OUT_MAX) ? burst_reg[(i + 1) % OUT_MAX] : '0;
            rem_next = rem_reg - LW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_len_reg   <= '0;
            pattern_bytes_reg <= '0;
            replace_len_reg   <= '0;
            replace_bytes_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                ssr_pkg::CFG_PATTERN_LEN:   pattern_len_reg   <= cfg_data[LW-1:0];
                ssr_pkg::CFG_PATTERN_BYTES: pattern_bytes_reg <= cfg_data;
                ssr_pkg::CFG_REPLACE_LEN:   replace_len_reg   <= cfg_data[LW-1:0];
                ssr_pkg::CFG_REPLACE_BYTES: replace_bytes_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_cnt_reg <= '0;
            rem_reg      <= '0;
            blast_reg    <= 1'b0;
        end
        else
        begin
            if (in_acc)
                held_cnt_reg <= held_cnt_next;
            rem_reg   <= rem_next;
            blast_reg <= blast_next;
        end
    end

    // payload: no reset
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            for (int j = 0; j < PAT_MAX; j++)
                held_reg[j] <= held_next[j];
        end
        for (int i = 0; i < OUT_MAX; i++)
            burst_reg[i] <= burst_next[i];
    end

endmodule

`default_nettype wire

FILE: hdl/ssr_checker.sv
// Port-level checks for the streaming substring replace block, bound to the top.
`default_nettype none

module ssr_checker (
    input wire                            clk,
    input wire                            rst_n,
    input wire                            s_tvalid,
    input wire                            s_tready,
    input wire                            s_tlast,
    input wire                            m_tvalid,
    input wire                            m_tready,
    input wire [ssr_pkg::BYTE_W-1:0]      m_tdata,
    input wire                            m_tlast
);

    // a stalled output beat holds
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled output beat changed");

    // no input is taken while a result beat is stalled
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |-> !s_tready)
        else $error("input accepted under output stall");

    // an empty output side never blocks input
    assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input blocked with no pending output");

    // the last byte of a string always produces output
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && s_tlast |=> m_tvalid)
        else $error("no output after last input beat");

endmodule

bind streaming_substring_replace ssr_checker u_ssr_checker (.*);

`default_nettype wire

FILE: bench/streaming_substring_replace_tb.sv
// Self-checking bench for streaming_substring_replace: directed strings, then random ones.
`timescale 1ns / 1ps

module streaming_substring_replace_tb;

    localparam int                  PAT_MAX       = 8;
    localparam int                  REP_MAX       = 8;
    localparam int                  SETTLE_CYCLES = 4;
    localparam int                  TAIL_CYCLES   = 16;
    localparam int                  RANDOM_BYTES  = 130;
    localparam int                  PRINT_CAP     = 100;
    localparam longint              TIMEOUT_NS    = 2_000_000;
    localparam ssr_pkg::cfg_idx_t   CFG_UNUSED_LO = ssr_pkg::cfg_idx_t'(4);
    localparam ssr_pkg::cfg_idx_t   CFG_UNUSED_HI = ssr_pkg::cfg_idx_t'(15);

    typedef struct packed {
        logic [ssr_pkg::BYTE_W-1:0] value;
        logic                       is_last;
    } out_beat_t;

    logic                           clk;
    logic                           rst_n;
    logic                           s_tvalid;
    logic                           s_tready;
    logic [ssr_pkg::BYTE_W-1:0]     s_tdata;
    logic                           s_tlast;
    logic                           m_tvalid;
    logic                           m_tready = 1'b0;
    logic [ssr_pkg::BYTE_W-1:0]     m_tdata;
    logic                           m_tlast;
    logic                           cfg_valid;
    logic                           cfg_ready;
    ssr_pkg::cfg_idx_t              cfg_index;
    logic [ssr_pkg::CFG_W-1:0]      cfg_data;

    // rewrite model state
    logic [ssr_pkg::LEN_W-1:0]      cur_pat_len;
    logic [ssr_pkg::CFG_W-1:0]      cur_pat;
    logic [ssr_pkg::LEN_W-1:0]      cur_rep_len;
    logic [ssr_pkg::CFG_W-1:0]      cur_rep;
    logic [ssr_pkg::BYTE_W-1:0]     held_buf [PAT_MAX];
    int unsigned                    held_n;

    out_beat_t                      pending_bytes [$];
    int unsigned                    mismatch_count;
    int unsigned                    bytes_sent;
    bit                             calm;

    streaming_substring_replace #(
        .PAT_MAX (PAT_MAX),
        .REP_MAX (REP_MAX)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #(TIMEOUT_NS);
        $display("status: fail");
        $finish;
    end

    always @(posedge clk)
    begin
        m_tready <= calm || ($urandom_range(99) >= 24);
    end

    task automatic report_mismatch(input string msg);
        if (mismatch_count < PRINT_CAP)
            $display("%0t ns: mismatch: %s", $time, msg);
        mismatch_count++;
    endtask

    always @(posedge clk)
    begin : check_output
        out_beat_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_bytes.size() == 0)
                report_mismatch($sformatf("unexpected beat %02h last %0b", m_tdata, m_tlast));
            else
            begin
                want = pending_bytes.pop_front();
                if (m_tdata !== want.value)
                    report_mismatch($sformatf("char_out %02h, want %02h", m_tdata, want.value));
                if (m_tlast !== want.is_last)
                    report_mismatch($sformatf("last_out %0b, want %0b on %02h",
                                              m_tlast, want.is_last, want.value));
            end
        end
    end

    function automatic bit held_is_pattern_prefix(input int unsigned plen);
        if (held_n > plen)
            return 1'b0;
        for (int unsigned i = 0; i < held_n; i++)
            if (held_buf[i] != cur_pat[8*i +: 8])
                return 1'b0;
        return 1'b1;
    endfunction

    // Work out the bytes one input byte releases and queue them.
    task automatic rewrite_byte(input logic [ssr_pkg::BYTE_W-1:0] ch, input logic is_last);
        logic [ssr_pkg::BYTE_W-1:0] burst [16];
        int unsigned                n;
        int unsigned                plen;
        int unsigned                rlen;
        out_beat_t                  beat;
        n    = 0;
        plen = (cur_pat_len > PAT_MAX) ? PAT_MAX : cur_pat_len;
        rlen = (cur_rep_len > REP_MAX) ? REP_MAX : cur_rep_len;
        if (held_n >= PAT_MAX)
            held_n = PAT_MAX - 1;
        if (plen == 0 || rlen == 0)
        begin
            for (int unsigned i = 0; i < held_n; i++)
            begin
                burst[n] = held_buf[i];
                n++;
            end
            held_n = 0;
            burst[n] = ch;
            n++;
        end
        else
        begin
            held_buf[held_n] = ch;
            held_n++;
            if (held_n == plen && held_is_pattern_prefix(plen))
            begin
                for (int unsigned i = 0; i < rlen; i++)
                begin
                    burst[n] = cur_rep[8*i +: 8];
                    n++;
                end
                held_n = 0;
            end
            else
            begin
                // release oldest bytes until what is left can still start a match
                while (held_n > 0 && !held_is_pattern_prefix(plen))
                begin
                    burst[n] = held_buf[0];
                    n++;
                    for (int unsigned i = 0; i + 1 < held_n; i++)
                        held_buf[i] = held_buf[i+1];
                    held_n--;
                end
            end
            if (is_last)
            begin
                for (int unsigned i = 0; i < held_n; i++)
                begin
                    burst[n] = held_buf[i];
                    n++;
                end
                held_n = 0;
            end
        end
        for (int unsigned k = 0; k < n; k++)
        begin
            beat.value   = burst[k];
            beat.is_last = is_last && (k == n - 1);
            pending_bytes.push_back(beat);
        end
    endtask

    // Leaves cfg_valid high; the next send_byte or wait_drained call lowers it.
    task automatic write_reg(input ssr_pkg::cfg_idx_t idx,
                             input logic [ssr_pkg::CFG_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            ssr_pkg::CFG_PATTERN_LEN:   cur_pat_len = val[ssr_pkg::LEN_W-1:0];
            ssr_pkg::CFG_PATTERN_BYTES: cur_pat     = val;
            ssr_pkg::CFG_REPLACE_LEN:   cur_rep_len = val[ssr_pkg::LEN_W-1:0];
            ssr_pkg::CFG_REPLACE_BYTES: cur_rep     = val;
            default: ;
        endcase
    endtask

    task automatic send_byte(input logic [ssr_pkg::BYTE_W-1:0] ch, input logic is_last);
        cfg_valid <= 1'b0;
        if (!calm && $urandom_range(99) < 24)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < 24)
                @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= ch;
        s_tlast  <= is_last;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        rewrite_byte(ch, is_last);
        bytes_sent++;
    endtask

    task automatic wait_drained();
        s_tvalid  <= 1'b0;
        cfg_valid <= 1'b0;
        while (pending_bytes.size() != 0)
            @(posedge clk);
        // a byte with no output may still be settling inside
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_rewrite(input logic [ssr_pkg::LEN_W-1:0] plen,
                               input logic [ssr_pkg::CFG_W-1:0] pat,
                               input logic [ssr_pkg::LEN_W-1:0] rlen,
                               input logic [ssr_pkg::CFG_W-1:0] rep);
        wait_drained();
        write_reg(ssr_pkg::CFG_PATTERN_LEN, ssr_pkg::CFG_W'(plen));
        write_reg(ssr_pkg::CFG_PATTERN_BYTES, pat);
        write_reg(ssr_pkg::CFG_REPLACE_LEN, ssr_pkg::CFG_W'(rlen));
        write_reg(ssr_pkg::CFG_REPLACE_BYTES, rep);
    endtask

    // Random string leaning on the pattern's own bytes so matches and near misses are common.
    task automatic send_string(input int unsigned len, input bit terminate);
        int unsigned                plen;
        int unsigned                k;
        int unsigned                pos;
        int unsigned                cut;
        int unsigned                roll;
        logic [ssr_pkg::BYTE_W-1:0] ch;
        plen = (cur_pat_len > PAT_MAX) ? PAT_MAX : cur_pat_len;
        k = 0;
        while (k < len)
        begin
            roll = $urandom_range(99);
            if (roll < 30 && plen != 0)
            begin
                cut = ($urandom_range(3) == 0) ? $urandom_range(1, plen) : plen;
                pos = 0;
                while (pos < cut && k < len)
                begin
                    send_byte(cur_pat[8*pos +: 8], terminate && (k == len - 1));
                    pos++;
                    k++;
                end
            end
            else
            begin
                if (roll < 85 && plen != 0)
                    ch = cur_pat[8*$urandom_range(0, plen - 1) +: 8];
                else
                    ch = ssr_pkg::BYTE_W'($urandom);
                send_byte(ch, terminate && (k == len - 1));
                k++;
            end
        end
    endtask

    function automatic logic [ssr_pkg::LEN_W-1:0] pick_len();
        int unsigned roll;
        roll = $urandom_range(9);
        if (roll == 0)
            return '0;
        if (roll == 1)
            return ssr_pkg::LEN_W'($urandom_range(9, 15));
        return ssr_pkg::LEN_W'($urandom_range(1, 8));
    endfunction

    task automatic test_passthrough();
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hA5, 1'b1);
    endtask

    task automatic test_unused_index();
        wait_drained();
        write_reg(CFG_UNUSED_LO, {ssr_pkg::CFG_W{1'b1}});
        write_reg(CFG_UNUSED_HI, 64'h0000_0000_0000_0808);
        send_byte(8'h61, 1'b1);
    endtask

    task automatic test_match_and_flush();
        set_rewrite(4'd2, 64'h6261, 4'd3, 64'h5A5958);
        send_byte(8'h61, 1'b0);
        send_byte(8'h61, 1'b0);
        send_byte(8'h62, 1'b0);
        send_byte(8'h61, 1'b0);
        send_byte(8'h62, 1'b0);
        send_byte(8'h61, 1'b1);
    endtask

    // replacement holds the pattern; scanning must not re-enter it
    task automatic test_replacement_has_pattern();
        set_rewrite(4'd1, 64'h61, 4'd2, 64'h6161);
        send_byte(8'h61, 1'b0);
        send_byte(8'h61, 1'b1);
    endtask

    // lengths above the maximum clamp to eight bytes
    task automatic test_saturated_lengths();
        logic [ssr_pkg::CFG_W-1:0] pat;
        pat = 64'hFF00_80_7F_01_FE_55_AA;
        set_rewrite(4'd15, pat, 4'd9, 64'h0123_4567_89AB_CDEF);
        for (int i = 0; i < PAT_MAX; i++)
            send_byte(pat[8*i +: 8], i == PAT_MAX - 1);
    endtask

    task automatic test_shorten_then_disable();
        set_rewrite(4'd4, 64'h7A797877, 4'd1, 64'h51);
        send_byte(8'h77, 1'b0);
        send_byte(8'h78, 1'b0);
        send_byte(8'h79, 1'b0);
        wait_drained();
        write_reg(ssr_pkg::CFG_PATTERN_LEN, ssr_pkg::CFG_W'(2));
        send_byte(8'h77, 1'b0);
        wait_drained();
        write_reg(ssr_pkg::CFG_REPLACE_LEN, ssr_pkg::CFG_W'(0));
        send_byte(8'h7A, 1'b1);
    endtask

    task automatic test_random_strings();
        int unsigned               start;
        int unsigned               phase;
        int unsigned               n_str;
        logic [ssr_pkg::LEN_W-1:0] plen;
        logic [ssr_pkg::LEN_W-1:0] rlen;
        logic [ssr_pkg::CFG_W-1:0] pat;
        logic [ssr_pkg::CFG_W-1:0] rep;
        start = bytes_sent;
        phase = 0;
        while (bytes_sent - start < RANDOM_BYTES)
        begin
            case (phase)
                0:       begin plen = 4'd8; rlen = 4'd8; end
                1:       begin plen = 4'd1; rlen = 4'd1; end
                default: begin plen = pick_len(); rlen = pick_len(); end
            endcase
            pat = {$urandom, $urandom};
            rep = ($urandom_range(3) == 0) ? pat : {$urandom, $urandom};
            // held bytes from an unterminated string carry into the new setting
            set_rewrite(plen, pat, rlen, rep);
            if ($urandom_range(3) == 0)
                write_reg(ssr_pkg::cfg_idx_t'($urandom_range(CFG_UNUSED_LO, CFG_UNUSED_HI)),
                          {$urandom, $urandom});
            calm  = (phase == 3);
            n_str = $urandom_range(2, 4);
            for (int unsigned s = 0; s < n_str; s++)
                send_string($urandom_range(1, 12), (s != n_str - 1) || ($urandom_range(4) != 0));
            wait_drained();
            calm = 1'b0;
            phase++;
        end
    endtask

    initial
    begin
        rst_n          = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        s_tlast        = 1'b0;
        cfg_valid      = 1'b0;
        cfg_index      = ssr_pkg::CFG_PATTERN_LEN;
        cfg_data       = '0;
        cur_pat_len    = '0;
        cur_pat        = '0;
        cur_rep_len    = '0;
        cur_rep        = '0;
        held_n         = 0;
        mismatch_count = 0;
        bytes_sent     = 0;
        calm           = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        test_passthrough();
        test_unused_index();
        test_match_and_flush();
        test_replacement_has_pattern();
        test_saturated_lengths();
        test_shorten_then_disable();
        test_random_strings();

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

FILE: sim.f
hdl/ssr_pkg.sv
hdl/streaming_substring_replace.sv
hdl/ssr_checker.sv
bench/streaming_substring_replace_tb.sv
